FILE: rtl/core/wam_pkg.sv
// Shared types, command codes and defaults for the wavetable ADSR mixer.
// No dependencies.
package wam_pkg;

  localparam int CHANNELS_DEF  = 4;
  localparam int TABLE_LEN_DEF = 256;

  localparam int MEM_DEPTH = 1024;
  localparam int MEM_AW    = 10;
  localparam int JOB_W     = 4;

  // item commands
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_ON    = 3'd2;
  localparam logic [2:0] CMD_OFF   = 3'd3;
  localparam logic [2:0] CMD_SET   = 3'd4;

  // envelope phases
  localparam logic [1:0] PH_HELD     = 2'd0;
  localparam logic [1:0] PH_RELEASED = 2'd1;
  localparam logic [1:0] PH_OFF      = 2'd2;

  // envelope segment picked for one channel in a tick
  localparam logic [2:0] EV_ATTACK = 3'd0;
  localparam logic [2:0] EV_DOWN   = 3'd1;
  localparam logic [2:0] EV_UP     = 3'd2;
  localparam logic [2:0] EV_HOLD   = 3'd3;
  localparam logic [2:0] EV_REL    = 3'd4;
  localparam logic [2:0] EV_END    = 3'd5;

  // divider jobs; jobs from JOB_SCALE up rescale one channel volume each
  localparam logic [JOB_W-1:0] JOB_RCP_A = 4'd0;
  localparam logic [JOB_W-1:0] JOB_RCP_D = 4'd1;
  localparam logic [JOB_W-1:0] JOB_RCP_R = 4'd2;
  localparam logic [JOB_W-1:0] JOB_SCALE = 4'd3;

  typedef struct packed {
    logic             capture;
    logic             apply;
    logic             clear_we;
    logic             div_start;
    logic [JOB_W-1:0] job;
    logic             tick_init;
    logic             tick_q;
    logic             tick_addr;
    logic             tick_mul;
    logic             tick_mix;
    logic             tick_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] item_cmd;
    logic       ch_ok;
    logic       ch_active;
    logic       div_busy;
    logic       out_busy;
  } dp_stat_t;

endpackage

FILE: rtl/core/wam_ctrl.sv
// Sequencer for the wavetable ADSR mixer: clearing pass, command apply,
// divider jobs and the per-channel tick steps. Uses wam_pkg.
module wam_ctrl #(
  parameter int CHANNELS = wam_pkg::CHANNELS_DEF,
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  wam_pkg::dp_stat_t             stat,
  output wam_pkg::dp_cmd_t              cmd,
  output logic [CH_W-1:0]               ch,
  output logic [wam_pkg::MEM_AW-1:0]    clr_addr
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_APPLY  = 4'd2;
  localparam logic [3:0] ST_DIV_GO = 4'd3;
  localparam logic [3:0] ST_DIV_WT = 4'd4;
  localparam logic [3:0] ST_T_CHK  = 4'd5;
  localparam logic [3:0] ST_T_Q    = 4'd6;
  localparam logic [3:0] ST_T_ADDR = 4'd7;
  localparam logic [3:0] ST_T_MUL  = 4'd8;
  localparam logic [3:0] ST_T_MIX  = 4'd9;
  localparam logic [3:0] ST_T_OUT  = 4'd10;

  localparam logic [wam_pkg::JOB_W-1:0] JOB_LAST = wam_pkg::JOB_W'(CHANNELS + 2);
  localparam logic [CH_W-1:0]           CH_LAST  = CH_W'(CHANNELS - 1);

  logic [3:0]                   state, state_next;
  logic [CH_W-1:0]              ch_next;
  logic [wam_pkg::JOB_W-1:0]    job, job_next;
  logic [wam_pkg::MEM_AW-1:0]   clr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      ch       <= '0;
      job      <= '0;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      ch       <= ch_next;
      job      <= job_next;
      clr_addr <= clr_next;
    end
  end

  always_comb begin
    state_next = state;
    ch_next    = ch;
    job_next   = job;
    clr_next   = clr_addr;
    cmd        = '0;
    cmd.job    = job;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_we = 1'b1;
        clr_next     = clr_addr + 1'b1;
        if (clr_addr == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_IDLE;
        if (stat.item_cmd == wam_pkg::CMD_TICK) begin
          cmd.tick_init = 1'b1;
          ch_next       = '0;
          state_next    = ST_T_CHK;
        end else if (stat.item_cmd == wam_pkg::CMD_SET && stat.ch_ok) begin
          job_next   = wam_pkg::JOB_RCP_A;
          state_next = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WT;
      end
      ST_DIV_WT: begin
        if (!stat.div_busy) begin
          if (job == JOB_LAST) begin
            state_next = ST_IDLE;
          end else begin
            job_next   = job + 1'b1;
            state_next = ST_DIV_GO;
          end
        end
      end
      ST_T_CHK: begin
        if (stat.ch_active) begin
          state_next = ST_T_Q;
        end else if (ch == CH_LAST) begin
          state_next = ST_T_OUT;
        end else begin
          ch_next = ch + 1'b1;
        end
      end
      ST_T_Q: begin
        cmd.tick_q = 1'b1;
        state_next = ST_T_ADDR;
      end
      ST_T_ADDR: begin
        cmd.tick_addr = 1'b1;
        state_next    = ST_T_MUL;
      end
      ST_T_MUL: begin
        cmd.tick_mul = 1'b1;
        state_next   = ST_T_MIX;
      end
      ST_T_MIX: begin
        cmd.tick_mix = 1'b1;
        if (ch == CH_LAST) begin
          state_next = ST_T_OUT;
        end else begin
          ch_next    = ch + 1'b1;
          state_next = ST_T_CHK;
        end
      end
      ST_T_OUT: begin
        if (!stat.out_busy) begin
          cmd.tick_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/wam_dp.sv
// Datapath of the wavetable ADSR mixer: channel state, wave table memory,
// shared restoring divider, envelope multipliers and mix accumulator. Uses wam_pkg.
module wam_dp #(
  parameter int CHANNELS  = wam_pkg::CHANNELS_DEF,
  parameter int TABLE_LEN = wam_pkg::TABLE_LEN_DEF,
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  wam_pkg::dp_cmd_t            cmd,
  input  logic [CH_W-1:0]             tch,
  input  logic [wam_pkg::MEM_AW-1:0]  clr_addr,
  output wam_pkg::dp_stat_t           stat,
  input  logic [2:0]                  in_cmd,
  input  logic [1:0]                  in_channel,
  input  logic [1:0]                  in_wave,
  input  logic [7:0]                  in_index,
  input  logic signed [7:0]           in_sample,
  input  logic [15:0]                 in_step,
  input  logic [7:0]                  in_level,
  input  logic [15:0]                 in_attack,
  input  logic [15:0]                 in_decay,
  input  logic [7:0]                  in_sustain,
  input  logic [15:0]                 in_release,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_data
);

  localparam logic [7:0]  SCALED_RST = 8'(255 / CHANNELS);
  localparam logic [16:0] MOD_MUL    = 17'((65536 + TABLE_LEN - 1) / TABLE_LEN);
  localparam logic [8:0]  TLEN       = 9'(TABLE_LEN);

  // latched item
  logic [2:0]        it_cmd;
  logic [1:0]        it_ch, it_wave;
  logic [7:0]        it_idx, it_level, it_sus;
  logic signed [7:0] it_smp;
  logic [15:0]       it_step, it_att, it_dec, it_rel;
  logic [CH_W-1:0]   ich;

  // channel state
  logic [15:0] cursor  [CHANNELS];
  logic [15:0] step    [CHANNELS];
  logic [7:0]  raw_vol [CHANNELS];
  logic [7:0]  scaled  [CHANNELS];
  logic [1:0]  wave    [CHANNELS];
  logic [1:0]  phase   [CHANNELS];
  logic [31:0] start_t [CHANNELS];
  logic [31:0] rel_t   [CHANNELS];
  logic [15:0] env_a   [CHANNELS];
  logic [15:0] env_d   [CHANNELS];
  logic [7:0]  env_s   [CHANNELS];
  logic [15:0] env_r   [CHANNELS];
  logic [24:0] rcp_a   [CHANNELS];
  logic [24:0] rcp_d   [CHANNELS];
  logic [24:0] rcp_r   [CHANNELS];
  logic [31:0] tick_count;

  logic [7:0] mem [wam_pkg::MEM_DEPTH];
  logic [7:0] mem_q;

  // divider
  logic [24:0]               div_q;
  logic [15:0]               div_rem, div_dvs;
  logic [4:0]                div_cnt;
  logic                      div_fin;
  logic [wam_pkg::JOB_W-1:0] div_job;
  logic [16:0]               div_sh;
  logic [15:0]               dvs_sel;
  logic [24:0]               dvd_sel;
  logic [CH_W-1:0]           sc_ch, fin_ch;
  logic [10:0]               vsum, vsum_eff;

  // tick pipeline
  logic [15:0] acc;
  logic [7:0]  qr;
  logic [31:0] tr, ur;
  logic [23:0] m1;
  logic [24:0] rsel;
  logic [31:0] p2;
  logic [2:0]  ecase;
  logic [7:0]  cur_hi, idx, v, s, ev, diff, m1a;
  logic [15:0] m1b;
  logic [24:0] qprod;
  logic [16:0] qlen;
  logic [16:0] ad_sum;
  logic [2:0]  ecase_next;
  logic [24:0] rsel_next;
  logic signed [16:0] mixp;

  assign ich = CH_W'(it_ch);
  assign stat.item_cmd  = it_cmd;
  assign stat.ch_ok     = ({2'b00, it_ch} < 4'(CHANNELS));
  assign stat.ch_active = (phase[tch] != wam_pkg::PH_OFF) && (step[tch] != 16'd0);
  assign stat.div_busy  = (div_cnt != 5'd0) || div_fin;
  assign stat.out_busy  = out_valid && !out_ready;

  always_comb begin
    vsum = '0;
    for (int i = 0; i < CHANNELS; i++) vsum = vsum + {3'b000, raw_vol[i]};
    vsum_eff = (vsum < 11'd255) ? 11'd255 : vsum;
  end

  assign sc_ch  = CH_W'(cmd.job - wam_pkg::JOB_SCALE);
  assign fin_ch = CH_W'(div_job - wam_pkg::JOB_SCALE);

  always_comb begin
    dvd_sel = 25'h1000000;
    case (cmd.job)
      wam_pkg::JOB_RCP_A: dvs_sel = env_a[ich];
      wam_pkg::JOB_RCP_D: dvs_sel = env_d[ich];
      wam_pkg::JOB_RCP_R: dvs_sel = env_r[ich];
      default: begin
        dvs_sel = {5'd0, vsum_eff};
        dvd_sel = 25'({17'd0, raw_vol[sc_ch]} * 25'd255);
      end
    endcase
  end

  assign div_sh = {div_rem, div_q[24]};

  // tick arithmetic
  assign cur_hi = cursor[tch][15:8];
  assign qprod  = {17'd0, cur_hi} * {8'd0, MOD_MUL};
  assign qlen   = {9'd0, qr} * {8'd0, TLEN};
  assign idx    = cur_hi - qlen[7:0];
  assign v      = scaled[tch];
  assign s      = env_s[tch];
  assign diff   = (s <= v) ? (v - s) : (s - v);
  assign ad_sum = {1'b0, env_a[tch]} + {1'b0, env_d[tch]};

  always_comb begin
    rsel_next = rcp_r[tch];
    m1a       = s;
    m1b       = env_r[tch] - ur[15:0];
    if (phase[tch] == wam_pkg::PH_HELD) begin
      if (tr < {16'd0, env_a[tch]}) begin
        ecase_next = wam_pkg::EV_ATTACK;
        m1a        = v;
        m1b        = tr[15:0];
        rsel_next  = rcp_a[tch];
      end else if (tr < {15'd0, ad_sum}) begin
        ecase_next = (s <= v) ? wam_pkg::EV_DOWN : wam_pkg::EV_UP;
        m1a        = diff;
        m1b        = tr[15:0] - env_a[tch];
        rsel_next  = rcp_d[tch];
      end else begin
        ecase_next = wam_pkg::EV_HOLD;
      end
    end else if (ur < {16'd0, env_r[tch]}) begin
      ecase_next = wam_pkg::EV_REL;
    end else begin
      ecase_next = wam_pkg::EV_END;
    end
  end

  always_comb begin
    case (ecase)
      wam_pkg::EV_ATTACK: ev = p2[31:24];
      wam_pkg::EV_DOWN:   ev = v - p2[31:24];
      wam_pkg::EV_UP:     ev = v + p2[31:24];
      wam_pkg::EV_HOLD:   ev = s;
      wam_pkg::EV_REL:    ev = p2[31:24];
      default:            ev = 8'd0;
    endcase
  end

  assign mixp = $signed(mem_q) * $signed({1'b0, ev});

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_cmd   <= in_cmd;
      it_ch    <= in_channel;
      it_wave  <= in_wave;
      it_idx   <= in_index;
      it_smp   <= in_sample;
      it_step  <= in_step;
      it_level <= in_level;
      it_att   <= in_attack;
      it_dec   <= in_decay;
      it_sus   <= in_sustain;
      it_rel   <= in_release;
    end
    if (cmd.tick_q) begin
      qr <= qprod[23:16];
      tr <= tick_count - start_t[tch];
      ur <= tick_count - rel_t[tch];
    end
    if (cmd.tick_addr) begin
      m1    <= {16'd0, m1a} * {8'd0, m1b};
      rsel  <= rsel_next;
      ecase <= ecase_next;
    end
    if (cmd.tick_mul) p2 <= 32'({25'd0, m1} * {24'd0, rsel});
    if (cmd.tick_init) acc <= '0;
    else if (cmd.tick_mix) acc <= acc + 16'(mixp);
    if (cmd.div_start) begin
      div_q   <= dvd_sel;
      div_dvs <= dvs_sel;
      div_rem <= '0;
      div_job <= cmd.job;
    end else if (div_cnt != 5'd0) begin
      if (div_sh >= {1'b0, div_dvs}) begin
        div_rem <= 16'(div_sh - {1'b0, div_dvs});
        div_q   <= {div_q[23:0], 1'b1};
      end else begin
        div_rem <= div_sh[15:0];
        div_q   <= {div_q[23:0], 1'b0};
      end
    end
  end

  // wave table memory
  always_ff @(posedge clk) begin
    if (cmd.clear_we) mem[clr_addr] <= 8'd0;
    else if (cmd.apply && it_cmd == wam_pkg::CMD_WRITE) mem[{it_wave, it_idx}] <= it_smp;
    if (cmd.tick_addr) mem_q <= mem[{wave[tch], idx}];
  end

  // channel state and control
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cursor[i]  <= '0;
        step[i]    <= '0;
        raw_vol[i] <= 8'd255;
        scaled[i]  <= SCALED_RST;
        wave[i]    <= '0;
        phase[i]   <= wam_pkg::PH_OFF;
        start_t[i] <= '0;
        rel_t[i]   <= '0;
        env_a[i]   <= '0;
        env_d[i]   <= '0;
        env_s[i]   <= '0;
        env_r[i]   <= '0;
        rcp_a[i]   <= '0;
        rcp_d[i]   <= '0;
        rcp_r[i]   <= '0;
      end
      tick_count <= '0;
      div_cnt    <= '0;
      div_fin    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.apply && stat.ch_ok) begin
        case (it_cmd)
          wam_pkg::CMD_ON: begin
            phase[ich] <= wam_pkg::PH_HELD;
            if (step[ich] != it_step) start_t[ich] <= tick_count;
            step[ich] <= it_step;
          end
          wam_pkg::CMD_OFF: begin
            if (phase[ich] == wam_pkg::PH_HELD) begin
              phase[ich] <= wam_pkg::PH_RELEASED;
              rel_t[ich] <= tick_count;
            end
            start_t[ich] <= tick_count;
          end
          wam_pkg::CMD_SET: begin
            wave[ich]    <= it_wave;
            raw_vol[ich] <= it_level;
            env_a[ich]   <= it_att;
            env_d[ich]   <= it_dec;
            env_s[ich]   <= it_sus;
            env_r[ich]   <= it_rel;
          end
          default: begin
          end
        endcase
      end
      if (cmd.div_start) div_cnt <= 5'd25;
      else if (div_cnt != 5'd0) div_cnt <= div_cnt - 1'b1;
      div_fin <= (div_cnt == 5'd1);
      if (div_fin) begin
        case (div_job)
          wam_pkg::JOB_RCP_A: rcp_a[ich] <= (div_dvs == 16'd0) ? 25'd0 : div_q;
          wam_pkg::JOB_RCP_D: rcp_d[ich] <= (div_dvs == 16'd0) ? 25'd0 : div_q;
          wam_pkg::JOB_RCP_R: rcp_r[ich] <= (div_dvs == 16'd0) ? 25'd0 : div_q;
          default:            scaled[fin_ch] <= div_q[7:0];
        endcase
      end
      if (cmd.tick_mix) begin
        if (ecase == wam_pkg::EV_END) begin
          phase[tch] <= wam_pkg::PH_OFF;
          step[tch]  <= '0;
        end else begin
          cursor[tch] <= cursor[tch] + step[tch];
        end
      end
      if (cmd.tick_out) begin
        out_valid  <= 1'b1;
        out_data   <= {~acc[15], acc[14:8]};
        tick_count <= tick_count + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/wavetable_adsr_mixer.sv
// Top level of the wavetable ADSR mixer: stream ports, field unpacking,
// controller wam_ctrl and datapath wam_dp. Uses wam_pkg.
//
// Four wave tables of 256 signed bytes are loaded by table-write items; each
// channel carries a waveform, a volume (rescaled so all volumes add to at
// most 255), ADSR times and an 8.8 phase step. A tick item returns one
// unsigned output byte; all other items return nothing. After reset the
// block runs a clearing pass over the table memory with s_tready low. A
// tick runs per-channel read / multiply / multiply / accumulate steps for
// each sounding channel and skips silent ones; a set-channel item runs
// the shared 25-step divider once for each of three envelope reciprocals
// and every rescaled volume. The output byte sits in a register, so the
// next item is taken while it waits; a second tick stalls in its last step
// until the first is taken.
module wavetable_adsr_mixer #(
  parameter int CHANNELS  = wam_pkg::CHANNELS_DEF,
  parameter int TABLE_LEN = wam_pkg::TABLE_LEN_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tuser: cmd[2:0]
  input  logic [2:0]   s_tuser,
  // tdata: channel[1:0] wave_select[3:2] table_index[11:4] sample_value[19:12]
  //        phase_step[35:20] level[43:36] attack_ticks[59:44]
  //        decay_ticks[75:60] sustain_level[83:76] release_ticks[99:84], zero pad
  input  logic [103:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: sample_out[7:0]
  output logic [7:0]   m_tdata
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  wam_pkg::dp_cmd_t           cmd;
  wam_pkg::dp_stat_t          stat;
  logic [CH_W-1:0]            ch;
  logic [wam_pkg::MEM_AW-1:0] clr_addr;

  wam_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd),
    .ch       (ch),
    .clr_addr (clr_addr)
  );

  wam_dp #(.CHANNELS(CHANNELS), .TABLE_LEN(TABLE_LEN)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .tch        (ch),
    .clr_addr   (clr_addr),
    .stat       (stat),
    .in_cmd     (s_tuser),
    .in_channel (s_tdata[1:0]),
    .in_wave    (s_tdata[3:2]),
    .in_index   (s_tdata[11:4]),
    .in_sample  (s_tdata[19:12]),
    .in_step    (s_tdata[35:20]),
    .in_level   (s_tdata[43:36]),
    .in_attack  (s_tdata[59:44]),
    .in_decay   (s_tdata[75:60]),
    .in_sustain (s_tdata[83:76]),
    .in_release (s_tdata[99:84]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata)
  );

endmodule

FILE: rtl/core/wam_check.sv
// Port-level checks for the wavetable ADSR mixer, bound to its top level.
// Depends on wavetable_adsr_mixer.
module wam_check (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output item dropped or changed while stalled");

  // reset starts the clearing pass with no output
  a_rst: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("ready or output valid right after reset");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken back to back");

  // no result in the cycle after an item is taken
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result appeared too early");

endmodule

bind wavetable_adsr_mixer wam_check u_wam_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
